[rtl/sre_pkg.sv]
// ============================================================================
// sre_pkg: shared types and constants for the streaming reduction engine
// Holds the mode codes, the controller states, the channel payloads, the
// command and status structs, and the floor(e^k) threshold table.
// ============================================================================
package sre_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF  = 64;
    localparam int COUNT_BITS_DEF = 25;
    localparam int MODE_W         = 4;
    localparam int EXP_TOP        = 43;

    typedef enum logic [MODE_W-1:0] {
        MODE_MAX     = 4'd0,
        MODE_MIN     = 4'd1,
        MODE_SUM     = 4'd2,
        MODE_MEAN    = 4'd3,
        MODE_SUMSQ   = 4'd4,
        MODE_L1      = 4'd5,
        MODE_L2      = 4'd6,
        MODE_PROD    = 4'd7,
        MODE_LOGSUM  = 4'd8,
        MODE_LOGSEXP = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_MUL,
        ST_MUL_HI,
        ST_UPDATE,
        ST_FINISH,
        ST_ITER,
        ST_RESULT,
        ST_OUTPUT
    } state_t;

    // Channel payloads.
    typedef struct packed {
        logic signed [DATA_WIDTH_DEF-1:0] element;
        logic                             last_of_group;
    } sre_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH_DEF-1:0] reduced_value;
        logic                             overflow;
        logic                             domain_error;
    } sre_out_t;

    typedef struct packed {
        logic [MODE_W-1:0] reduce_mode;
    } sre_cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;       // capture the incoming element
        logic mul;        // register the lower partial product
        logic mul_hi;     // register the full product / square
        logic update;     // fold into the accumulator
        logic fin_start;  // set up the end-of-group unit
        logic fin_step;   // one iteration of the end-of-group unit
        logic result;     // form the saturated result
    } sre_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic last;       // held element closes the group
        logic fin_done;   // end-of-group iterations complete
    } sre_sts_t;

    function automatic logic [63:0] expf(input logic [5:0] k);
        logic [63:0] v;
        case (k)
            6'd0:  v = 64'd1;
            6'd1:  v = 64'd2;
            6'd2:  v = 64'd7;
            6'd3:  v = 64'd20;
            6'd4:  v = 64'd54;
            6'd5:  v = 64'd148;
            6'd6:  v = 64'd403;
            6'd7:  v = 64'd1096;
            6'd8:  v = 64'd2980;
            6'd9:  v = 64'd8103;
            6'd10: v = 64'd22026;
            6'd11: v = 64'd59874;
            6'd12: v = 64'd162754;
            6'd13: v = 64'd442413;
            6'd14: v = 64'd1202604;
            6'd15: v = 64'd3269017;
            6'd16: v = 64'd8886110;
            6'd17: v = 64'd24154952;
            6'd18: v = 64'd65659969;
            6'd19: v = 64'd178482300;
            6'd20: v = 64'd485165195;
            6'd21: v = 64'd1318815734;
            6'd22: v = 64'd3584912846;
            6'd23: v = 64'd9744803446;
            6'd24: v = 64'd26489122129;
            6'd25: v = 64'd72004899337;
            6'd26: v = 64'd195729609428;
            6'd27: v = 64'd532048240601;
            6'd28: v = 64'd1446257064291;
            6'd29: v = 64'd3931334297144;
            6'd30: v = 64'd10686474581524;
            6'd31: v = 64'd29048849665247;
            6'd32: v = 64'd78962960182680;
            6'd33: v = 64'd214643579785916;
            6'd34: v = 64'd583461742527454;
            6'd35: v = 64'd1586013452313430;
            6'd36: v = 64'd4311231547115195;
            6'd37: v = 64'd11719142372802611;
            6'd38: v = 64'd31855931757113756;
            6'd39: v = 64'd86593400423993746;
            6'd40: v = 64'd235385266837019985;
            6'd41: v = 64'd639843493530054949;
            6'd42: v = 64'd1739274941520501047;
            6'd43: v = 64'd4727839468229346561;
            default: v = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return v;
    endfunction

endpackage

[rtl/sre_if.sv]
// ============================================================================
// sre_stream_if: valid/ready channel
// Generic payload channel; a transfer happens when valid and ready are high.
// ============================================================================
interface sre_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/sre_ctrl.sv]
// ============================================================================
// sre_ctrl: sequencing controller
// Steps each element through capture, two multiply halves and accumulate,
// and at the end of a group through the iterative finishing unit and the
// output.
// ============================================================================
module sre_ctrl
    import sre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output sre_cmd_t cmd,
    input  sre_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: if (in_valid) state_next = ST_MUL;
            ST_MUL:    state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_UPDATE;
            ST_UPDATE: state_next = sts.last ? ST_FINISH : ST_ACCEPT;
            ST_FINISH: state_next = ST_ITER;
            ST_ITER:   if (sts.fin_done) state_next = ST_RESULT;
            ST_RESULT: state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_ready) state_next = ST_ACCEPT;
            default:   state_next = ST_ACCEPT;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_ACCEPT:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_MUL_HI: cmd.mul_hi = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_FINISH: cmd.fin_start = 1'b1;
            ST_ITER:   cmd.fin_step = ~sts.fin_done;
            ST_RESULT: cmd.result = 1'b1;
            ST_OUTPUT: out_valid = 1'b1;
            default:   cmd = '0;
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_take_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> cmd.mul)
        else $error("captured element not multiplied");
    a_mul_hi: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> cmd.mul_hi)
        else $error("lower partial product not followed by upper");

endmodule

[rtl/sre_datapath.sv]
// ============================================================================
// sre_datapath: accumulator, count and end-of-group arithmetic
// One 32x32 multiplier used for both halves of the 64x32 magnitude product,
// a saturating accumulator, and a bit-serial unit doing restoring division,
// square root or the log table search at the end of a group.
// ============================================================================
module sre_datapath
    import sre_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [MODE_W-1:0]            mode,
    input  logic [DATA_WIDTH_DEF-1:0]    element,
    input  logic                         last_of_group,
    input  sre_cmd_t                     cmd,
    output sre_sts_t                     sts,
    output logic [DATA_WIDTH_DEF-1:0]    reduced_value,
    output logic                         overflow,
    output logic                         domain_error
);

    localparam logic [63:0] ACC_HI = 64'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
    localparam logic [63:0] ACC_LO = ~ACC_HI;
    localparam logic [63:0] OUT_HI = 64'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
    localparam logic [63:0] OUT_LO = ~OUT_HI;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // element and group state
    logic signed [63:0]     e_reg;
    logic                   last_reg;
    logic signed [63:0]     acc_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic                   started_reg;
    logic                   sticky_reg;
    logic [63:0]            plo_reg;
    logic [63:0]            prod_reg;
    logic                   pbig_reg;

    // element sign-extended from DATA_WIDTH bits
    logic signed [63:0] e_in;
    assign e_in = 64'(signed'(element[DATA_WIDTH-1:0]));

    // multiplier operands: prod uses |acc|*|e|, squares use |e|*|e|
    logic               first;
    logic signed [63:0] acc_base;
    logic [63:0]        ma;
    logic [63:0]        mb;
    logic [31:0]        mul_a;
    logic [63:0]        mul_p;
    logic [64:0]        hi_sum;

    assign first = ~started_reg;
    always_comb
    begin
        if (first)
        begin
            if (mode == MODE_MAX || mode == MODE_MIN) acc_base = e_reg;
            else if (mode == MODE_PROD) acc_base = 64'sd1;
            else acc_base = '0;
        end
        else
        begin
            acc_base = acc_reg;
        end
    end

    assign mb = e_reg[63] ? 64'(-e_reg) : 64'(e_reg);
    assign ma = (mode == MODE_PROD) ? (acc_base[63] ? 64'(-acc_base) : 64'(acc_base)) : mb;

    // |e| fits in 32 bits, so the product is two partial products: the
    // lower half of ma first, then the upper half folded onto it.
    assign mul_a  = cmd.mul_hi ? ma[63:32] : ma[31:0];
    assign mul_p  = 64'(mul_a) * 64'(mb[31:0]);
    assign hi_sum = 65'(mul_p) + 65'(plo_reg[63:32]);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            e_reg    <= e_in;
            last_reg <= last_of_group;
        end
        if (cmd.mul)
        begin
            plo_reg <= mul_p;
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= {hi_sum[31:0], plo_reg[31:0]};
            pbig_reg <= (hi_sum[64:32] != '0);
        end
    end

    // addend and update
    logic               add_ovf;
    logic [63:0]        addend;
    logic signed [64:0] sum;
    logic signed [63:0] acc_new;
    logic               upd_ovf;
    logic               neg_p;
    logic [63:0]        plim;
    logic [5:0]         eidx;

    assign eidx  = e_reg[5:0];
    assign neg_p = acc_base[63] ^ e_reg[63];
    assign plim  = neg_p ? ACC_HI + 64'd1 : ACC_HI;

    always_comb
    begin
        addend  = '0;
        add_ovf = 1'b0;
        case (mode)
            MODE_MAX, MODE_MIN, MODE_PROD:
            begin
                // no addend; these modes saturate on their own
                add_ovf = 1'b0;
            end
            MODE_SUMSQ, MODE_L2:
            begin
                if (pbig_reg || prod_reg > ACC_HI)
                begin
                    addend = ACC_HI; add_ovf = 1'b1;
                end
                else addend = prod_reg;
            end
            MODE_L1:
            begin
                if (mb > ACC_HI) begin addend = ACC_HI; add_ovf = 1'b1; end
                else addend = mb;
            end
            MODE_LOGSEXP:
            begin
                if (e_reg[63]) addend = '0;
                else if (e_reg > 64'(EXP_TOP))
                begin
                    addend = ACC_HI; add_ovf = 1'b1;
                end
                else if (expf(eidx) > ACC_HI)
                begin
                    addend = ACC_HI; add_ovf = 1'b1;
                end
                else addend = expf(eidx);
            end
            default:
            begin
                if (mb > ACC_HI)
                begin
                    addend = e_reg[63] ? 64'(-ACC_HI) : ACC_HI; add_ovf = 1'b1;
                end
                else addend = 64'(e_reg);
            end
        endcase
    end

    assign sum = 65'(acc_base) + 65'(signed'(addend));

    always_comb
    begin
        upd_ovf = add_ovf;
        acc_new = acc_base;
        case (mode)
            MODE_MAX: if (e_reg > acc_base) acc_new = e_reg;
            MODE_MIN: if (e_reg < acc_base) acc_new = e_reg;
            MODE_PROD:
            begin
                if (ma == '0 || mb == '0) acc_new = '0;
                else if (pbig_reg || prod_reg > plim)
                begin
                    upd_ovf = 1'b1;
                    acc_new = neg_p ? signed'(ACC_LO) : signed'(ACC_HI);
                end
                else acc_new = neg_p ? 64'(-prod_reg) : signed'(prod_reg);
            end
            default:
            begin
                if (sum > 65'(signed'(ACC_HI)))
                begin
                    acc_new = signed'(ACC_HI); upd_ovf = 1'b1;
                end
                else if (sum < 65'(signed'(ACC_LO)))
                begin
                    acc_new = signed'(ACC_LO); upd_ovf = 1'b1;
                end
                else acc_new = sum[63:0];
            end
        endcase
    end

    // end-of-group serial unit
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] bit_reg;
    logic [6:0]  step_reg;
    logic        done_reg;
    logic [63:0] amag;
    logic [64:0] trial;
    logic [63:0] root_try;

    assign amag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);

    always_comb
    begin
        trial    = '0;
        root_try = q_reg + bit_reg;
        if (mode == MODE_MEAN)
        begin
            trial = {rem_reg, q_reg[63]} - 65'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.update) started_reg <= ~last_reg;
            if (cmd.fin_start) done_reg <= 1'b0;
            else if (cmd.fin_step && step_reg == 7'd1) done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            acc_reg <= acc_new;
            if (first)
            begin
                cnt_reg    <= COUNT_BITS'(1);
                sticky_reg <= upd_ovf;
            end
            else if (cnt_reg != CMAX)
            begin
                cnt_reg    <= cnt_reg + COUNT_BITS'(1);
                sticky_reg <= sticky_reg | upd_ovf;
            end
            else sticky_reg <= 1'b1;
        end
        if (cmd.fin_start)
        begin
            bit_reg <= 64'd1 << 62;
            case (mode)
                MODE_MEAN:
                begin
                    rem_reg  <= '0;
                    q_reg    <= amag;
                    step_reg <= 7'd64;
                end
                MODE_L2:
                begin
                    rem_reg  <= amag;
                    q_reg    <= '0;
                    step_reg <= 7'd32;
                end
                MODE_LOGSUM, MODE_LOGSEXP:
                begin
                    rem_reg  <= amag;
                    q_reg    <= '0;
                    step_reg <= 7'(EXP_TOP);
                end
                default: step_reg <= 7'd1;
            endcase
        end
        else if (cmd.fin_step)
        begin
            step_reg <= step_reg - 7'd1;
            case (mode)
                MODE_MEAN:
                begin
                    if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], q_reg[63]};
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                end
                MODE_L2:
                begin
                    if (rem_reg >= root_try)
                    begin
                        rem_reg <= rem_reg - root_try;
                        q_reg   <= (q_reg >> 1) + bit_reg;
                    end
                    else q_reg <= q_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                MODE_LOGSUM, MODE_LOGSEXP:
                begin
                    if (rem_reg > expf(step_reg[5:0])) q_reg <= q_reg + 64'd1;
                end
                default: q_reg <= q_reg;
            endcase
        end
    end

    assign sts.last     = last_reg;
    assign sts.fin_done = done_reg;

    // result
    logic signed [63:0] res;
    logic               dom;
    logic [DATA_WIDTH_DEF-1:0] val_reg;
    logic               ovf_reg;
    logic               dom_reg;

    always_comb
    begin
        dom = 1'b0;
        case (mode)
            MODE_MEAN: res = acc_reg[63] ? 64'(-q_reg) : signed'(q_reg);
            MODE_L2:   res = signed'(q_reg);
            MODE_LOGSUM, MODE_LOGSEXP:
            begin
                if (acc_reg <= 0)
                begin
                    dom = 1'b1; res = '0;
                end
                else res = signed'(q_reg);
            end
            default:   res = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            dom_reg <= dom;
            if (res > signed'(OUT_HI))
            begin
                val_reg <= DATA_WIDTH_DEF'(OUT_HI); ovf_reg <= 1'b1;
            end
            else if (res < signed'(OUT_LO))
            begin
                val_reg <= DATA_WIDTH_DEF'(OUT_LO); ovf_reg <= 1'b1;
            end
            else
            begin
                val_reg <= res[DATA_WIDTH_DEF-1:0]; ovf_reg <= sticky_reg;
            end
        end
    end

    assign reduced_value = val_reg;
    assign overflow      = ovf_reg;
    assign domain_error  = dom_reg;

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |=> !started_reg)
        else $error("group not closed after last element");
    a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_start |-> cnt_reg != '0)
        else $error("group closed with zero count");
    a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_step |-> !done_reg)
        else $error("finishing unit stepped after done");

endmodule

[rtl/streaming_reduction_engine.sv]
// ============================================================================
// streaming_reduction_engine: grouped min/max/sum/mean/norm/prod/log reduce
// Reduces a stream of signed elements into one saturated value per group.
// ============================================================================
// Usage:
//   in_ch  : element and last_of_group; one transfer per element.
//   out_ch : reduced_value, overflow, domain_error; one transfer per group,
//            after the element with last_of_group set.
//   cfg_ch : reduce_mode write data (4 bits); write only while idle.
// Sequence:
//   An element passes through capture, low and high multiply halves and
//   accumulate; the single 32x32 multiplier is shared by both halves, and a
//   new element is accepted only once the accumulate is done.
//   A closing element then runs the bit-serial finishing unit: a restoring
//   divide for mean, a square root for L2, a threshold table walk for the log
//   modes and a plain pass for the rest; then the result is formed and output.
// Reset:
//   Clears the controller, group state and sets reduce_mode to sum.
// Stall:
//   A result holds on out_ch until taken; input is not accepted meanwhile.
// ============================================================================
module streaming_reduction_engine
    import sre_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    sre_stream_if.sink   in_ch,
    sre_stream_if.source out_ch,
    sre_stream_if.sink   cfg_ch
);

    logic [MODE_W-1:0] mode_reg;
    sre_cmd_t          cmd;
    sre_sts_t          sts;

    // Configuration is always ready; hold the mode between writes.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SUM;
        end
        else if (cfg_ch.valid)
        begin
            mode_reg <= cfg_ch.data.reduce_mode;
        end
    end

    sre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sre_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .element       (in_ch.data.element),
        .last_of_group (in_ch.data.last_of_group),
        .cmd           (cmd),
        .sts           (sts),
        .reduced_value (out_ch.data.reduced_value),
        .overflow      (out_ch.data.overflow),
        .domain_error  (out_ch.data.domain_error)
    );

endmodule

[tb/sv/testbench.sv]
// ============================================================================
// testbench: self-checking bench for the streaming reduction engine
// Drives groups of signed elements in every reduce mode, folds each transfer
// into a local accumulator model and checks every reduced value, overflow and
// domain flag against it, with random stalls on both channels.
// ============================================================================
module testbench
    import sre_pkg::*;
();

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam int unsigned COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES = 100;

    // floor(e^k), k = 0..43
    localparam logic [63:0] EXP_FLOOR [0:43] = '{
        64'd1, 64'd2, 64'd7, 64'd20, 64'd54, 64'd148, 64'd403, 64'd1096,
        64'd2980, 64'd8103, 64'd22026, 64'd59874, 64'd162754, 64'd442413,
        64'd1202604, 64'd3269017, 64'd8886110, 64'd24154952, 64'd65659969,
        64'd178482300, 64'd485165195, 64'd1318815734, 64'd3584912846,
        64'd9744803446, 64'd26489122129, 64'd72004899337, 64'd195729609428,
        64'd532048240601, 64'd1446257064291, 64'd3931334297144,
        64'd10686474581524, 64'd29048849665247, 64'd78962960182680,
        64'd214643579785916, 64'd583461742527454, 64'd1586013452313430,
        64'd4311231547115195, 64'd11719142372802611, 64'd31855931757113756,
        64'd86593400423993746, 64'd235385266837019985, 64'd639843493530054949,
        64'd1739274941520501047, 64'd4727839468229346561
    };

    logic clk;
    logic rst_n;

    sre_stream_if #(.payload_t(sre_in_t))  in_if ();
    sre_stream_if #(.payload_t(sre_out_t)) out_if ();
    sre_stream_if #(.payload_t(sre_cfg_t)) cfg_if ();

    streaming_reduction_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if.sink),
        .out_ch (out_if.source),
        .cfg_ch (cfg_if.sink)
    );

    // Model state, mirrors what the engine holds between transfers
    logic [MODE_W-1:0] cur_mode;
    longint            acc;
    int unsigned       elem_count;
    logic              in_group;
    logic              sticky_ovf;

    sre_out_t pending_results [$];
    int       error_count;
    logic     steady;          // set to suppress idling on both sides

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Accumulator arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input longint v);
        logic [63:0] u;
        u = v;
        return (v < 0) ? -u : u;
    endfunction

    function automatic longint signed_from_mag(input logic [63:0] m, input logic neg);
        if (m == 0)
            return 0;
        return neg ? -longint'(m - 1) - 1 : longint'(m);
    endfunction

    function automatic longint add_saturating(input longint a, input longint b);
        if (b > 0 && a > ACC_MAX - b)
        begin
            sticky_ovf = 1'b1;
            return ACC_MAX;
        end
        if (b < 0 && a < ACC_MIN - b)
        begin
            sticky_ovf = 1'b1;
            return ACC_MIN;
        end
        return a + b;
    endfunction

    function automatic longint mul_saturating(input longint a, input longint b);
        logic        neg;
        logic [63:0] ma, mb, lim;
        neg = (a < 0) != (b < 0);
        ma  = magnitude(a);
        mb  = magnitude(b);
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (ma == 0 || mb == 0)
            return 0;
        if (ma > lim / mb)
        begin
            sticky_ovf = 1'b1;
            return neg ? ACC_MIN : ACC_MAX;
        end
        return signed_from_mag(ma * mb, neg);
    endfunction

    function automatic longint clip_to_acc(input logic [63:0] m);
        if (m > 64'h7FFF_FFFF_FFFF_FFFF)
        begin
            sticky_ovf = 1'b1;
            return ACC_MAX;
        end
        return longint'(m);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint floor_ln(input logic [63:0] x);
        longint n;
        n = 0;
        for (int k = 1; k <= EXP_TOP; k++)
            if (x > EXP_FLOOR[k])
                n++;
        return n;
    endfunction

    // Fold one accepted element; queue a result when it closes the group
    function automatic void fold_element(input logic signed [31:0] e32, input logic last);
        longint   e, res;
        logic     dom;
        sre_out_t r;
        e   = e32;
        dom = 1'b0;
        if (!in_group)
        begin
            in_group   = 1'b1;
            elem_count = 0;
            sticky_ovf = 1'b0;
            if (cur_mode == MODE_MAX || cur_mode == MODE_MIN)
                acc = e;
            else
                acc = (cur_mode == MODE_PROD) ? 1 : 0;
        end
        case (cur_mode)
            MODE_MAX:     if (e > acc) acc = e;
            MODE_MIN:     if (e < acc) acc = e;
            MODE_SUMSQ,
            MODE_L2:      acc = add_saturating(acc, clip_to_acc(magnitude(e) * magnitude(e)));
            MODE_L1:      acc = add_saturating(acc, clip_to_acc(magnitude(e)));
            MODE_PROD:    acc = mul_saturating(acc, e);
            MODE_LOGSEXP:
            begin
                if (e > EXP_TOP)
                    acc = add_saturating(acc, clip_to_acc(64'hFFFF_FFFF_FFFF_FFFF));
                else if (e >= 0)
                    acc = add_saturating(acc, clip_to_acc(EXP_FLOOR[e]));
            end
            default:      acc = add_saturating(acc, e);
        endcase
        if (elem_count < COUNT_MAX)
            elem_count++;
        else
            sticky_ovf = 1'b1;
        if (!last)
            return;
        case (cur_mode)
            MODE_MEAN:
                res = signed_from_mag(magnitude(acc) / elem_count, acc < 0);
            MODE_L2:
                res = longint'(floor_sqrt(magnitude(acc)));
            MODE_LOGSUM,
            MODE_LOGSEXP:
            begin
                if (acc <= 0)
                begin
                    dom = 1'b1;
                    res = 0;
                end
                else
                    res = floor_ln(acc);
            end
            default:
                res = acc;
        endcase
        if (res > 64'sh7FFF_FFFF)
        begin
            res = 64'sh7FFF_FFFF;
            sticky_ovf = 1'b1;
        end
        if (res < -64'sh8000_0000)
        begin
            res = -64'sh8000_0000;
            sticky_ovf = 1'b1;
        end
        r.reduced_value = res[31:0];
        r.overflow      = sticky_ovf;
        r.domain_error  = dom;
        pending_results = {pending_results, r};
        in_group = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare each output transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sre_out_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_if.data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_if.data.reduced_value !== want.reduced_value)
                begin
                    $error("reduced_value: expected %0d, got %0d",
                           want.reduced_value, out_if.data.reduced_value);
                    error_count++;
                end
                if (out_if.data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, out_if.data.overflow);
                    error_count++;
                end
                if (out_if.data.domain_error !== want.domain_error)
                begin
                    $error("domain_error: expected %0b, got %0b",
                           want.domain_error, out_if.data.domain_error);
                    error_count++;
                end
            end
        end
        // stall the result side at random unless a steady stretch is running
        out_if.ready <= steady || ($urandom_range(99) >= 37);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one element; hold valid high on return so back-to-back transfers
    // need no second assignment in the same step
    task automatic send_element(input logic signed [31:0] e, input logic last);
        while (!steady && $urandom_range(99) < 37)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid              <= 1'b1;
        in_if.data.element       <= e;
        in_if.data.last_of_group <= last;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        fold_element(e, last);
    endtask

    // Drain all expected results, let the engine settle, then write the mode
    task automatic write_mode(input logic [MODE_W-1:0] m);
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.data.reduce_mode <= m;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic signed [31:0] pick_element(input logic [MODE_W-1:0] m);
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (sel < 55 || m == MODE_PROD || m == MODE_LOGSEXP)
            return $signed($urandom_range(60)) - 8;
        return $urandom();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes in every mode, log of non-positive, exp out of range,
    // undefined modes, and a mode switch in the middle of a group
    task automatic test_directed();
        for (int m = MODE_MAX; m <= MODE_LOGSEXP; m++)
        begin
            write_mode(MODE_W'(m));
            send_element(32'sh7FFF_FFFF, 1'b0);
            send_element(32'sh8000_0000, 1'b1);
        end
        write_mode(MODE_LOGSUM);
        send_element(0, 1'b1);
        write_mode(MODE_LOGSEXP);
        send_element(44, 1'b0);
        send_element(-1, 1'b1);
        write_mode(4'd15);
        send_element(-5, 1'b1);
        write_mode(4'd10);
        send_element(12, 1'b0);
        write_mode(MODE_PROD);
        send_element(3, 1'b1);
    endtask

    task automatic test_random_groups(input int n_items);
        int sent, glen;
        logic [MODE_W-1:0] m;
        sent = 0;
        while (sent < n_items)
        begin
            m = MODE_W'($urandom_range(15));
            write_mode(m);
            // keep one phase free of any idling
            steady = (sent >= n_items / 2 && sent < n_items / 2 + 40);
            for (int g = 0; g < 4; g++)
            begin
                glen = $urandom_range(6) + 1;
                for (int i = 0; i < glen; i++)
                    send_element(pick_element(m), i == glen - 1);
                sent += glen;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        steady      = 1'b0;
        error_count = 0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        cur_mode    = MODE_SUM;
        acc         = 0;
        elem_count  = 0;
        in_group    = 1'b0;
        sticky_ovf  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_groups(370);
        write_mode(MODE_SUM);

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop if the engine hangs
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
